/* sv/ptc_pkg.sv */
// ptc_pkg: shared constants, register codes and the divider sideband type
// for the pressure and temperature compensation pipeline
// no dependencies
package ptc_pkg;

    localparam int RawW     = 20;
    localparam int CalW     = 48;
    localparam int DataW    = 64;
    localparam int AddrW    = 5;
    localparam int CelW     = 15;
    localparam int FahW     = 16;
    localparam int PaW      = 17;
    localparam int DenW     = 31;
    localparam int DivSteps = 64;

    localparam logic signed [CelW-1:0] CelMin = -15'sd4000;
    localparam logic signed [CelW-1:0] CelMax = 15'sd8500;
    localparam logic [PaW-1:0] PaMin = 17'd30000;
    localparam logic [PaW-1:0] PaMax = 17'd110000;

    typedef enum logic [1:0] {
        REG_TEMP_CAL   = 2'd0,
        REG_PRESS_LOW  = 2'd1,
        REG_PRESS_MID  = 2'd2,
        REG_PRESS_HIGH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                   neg;
        logic                   fault;
        logic signed [CelW-1:0] cel;
        logic signed [FahW-1:0] fah;
    } t_div_side;

endpackage

/* sv/ptc_div.sv */
// ptc_div: fully pipelined unsigned restoring divider, one quotient bit per stage
// uses ptc_pkg for widths and the sideband type
module ptc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [ptc_pkg::DataW-1:0]  i_num,
    input  logic [ptc_pkg::DenW-1:0]   i_den,
    input  ptc_pkg::t_div_side         i_side,
    output logic                       o_vld,
    output logic [ptc_pkg::DataW-1:0]  o_quo,
    output ptc_pkg::t_div_side         o_side
);
    import ptc_pkg::*;

    logic [DenW-1:0]  r_rem  [DivSteps];
    logic [DataW-1:0] r_w    [DivSteps];
    logic [DenW-1:0]  r_den  [DivSteps];
    t_div_side        r_side [DivSteps];
    logic [DivSteps-1:0] r_vld;

    for (genvar k = 0; k < DivSteps; k++) begin : g_stage
        logic [DenW-1:0]  rem_in;
        logic [DataW-1:0] w_in;
        logic [DenW-1:0]  den_in;
        t_div_side        side_in;
        logic             vld_in;
        logic [DenW:0]    trial;
        logic [DenW:0]    diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign w_in    = i_num;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign w_in    = r_w[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // shift the next dividend bit into the partial remainder
        assign trial = {rem_in, w_in[DataW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
                r_w[k]    <= {w_in[DataW-2:0], ge};
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[DivSteps-1];
    assign o_quo  = r_w[DivSteps-1];
    assign o_side = r_side[DivSteps-1];

endmodule

/* sv/pressure_temperature_compensation_unit.sv */
// pressure_temperature_compensation_unit: barometric compensation pipeline
// accepts one transaction per cycle while the skid stage is empty
// the 64-stage divider and the multiplier stages are each fully pipelined
// a two-entry output register and skid stage keep input accepted while one result waits
// synchronous active-low reset clears all valid bits and the calibration registers to zero
// uses ptc_pkg and ptc_div
module pressure_temperature_compensation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ptc_pkg::RawW-1:0]          i_raw_temperature,
    input  logic [ptc_pkg::RawW-1:0]          i_raw_pressure,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [ptc_pkg::CelW-1:0]   o_celsius_hundredths,
    output logic signed [ptc_pkg::FahW-1:0]   o_fahrenheit_hundredths,
    output logic [ptc_pkg::PaW-1:0]           o_pressure_pascal,
    output logic                              o_divide_fault,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ptc_pkg::AddrW-1:0]         paddr,
    input  logic [ptc_pkg::DataW-1:0]         pwdata,
    output logic [ptc_pkg::DataW-1:0]         prdata,
    output logic                              pready
);
    import ptc_pkg::*;

    // ---------------- configuration ----------------
    logic [CalW-1:0] r_temp_cal, r_press_low, r_press_mid, r_press_high;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_cal   <= '0;
            r_press_low  <= '0;
            r_press_mid  <= '0;
            r_press_high <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg_idx'(paddr[AddrW-1:3]))
                REG_TEMP_CAL:   r_temp_cal   <= pwdata[CalW-1:0];
                REG_PRESS_LOW:  r_press_low  <= pwdata[CalW-1:0];
                REG_PRESS_MID:  r_press_mid  <= pwdata[CalW-1:0];
                REG_PRESS_HIGH: r_press_high <= pwdata[CalW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[AddrW-1:3]))
            REG_TEMP_CAL:   prdata = {16'b0, r_temp_cal};
            REG_PRESS_LOW:  prdata = {16'b0, r_press_low};
            REG_PRESS_MID:  prdata = {16'b0, r_press_mid};
            REG_PRESS_HIGH: prdata = {16'b0, r_press_high};
            default:        prdata = '0;
        endcase
    end

    logic [15:0]        cal_t1, cal_p1;
    logic signed [15:0] cal_t2, cal_t3, cal_p2, cal_p3, cal_p4, cal_p5;
    logic signed [15:0] cal_p6, cal_p7, cal_p8, cal_p9;

    assign cal_t1 = r_temp_cal[15:0];
    assign cal_t2 = $signed(r_temp_cal[31:16]);
    assign cal_t3 = $signed(r_temp_cal[47:32]);
    assign cal_p1 = r_press_low[15:0];
    assign cal_p2 = $signed(r_press_low[31:16]);
    assign cal_p3 = $signed(r_press_low[47:32]);
    assign cal_p4 = $signed(r_press_mid[15:0]);
    assign cal_p5 = $signed(r_press_mid[31:16]);
    assign cal_p6 = $signed(r_press_mid[47:32]);
    assign cal_p7 = $signed(r_press_high[15:0]);
    assign cal_p8 = $signed(r_press_high[31:16]);
    assign cal_p9 = $signed(r_press_high[47:32]);

    // ---------------- flow control ----------------
    logic r_out_vld, r_skid_vld;
    logic w_en;

    assign w_en    = !r_skid_vld;
    // no transaction is taken while reset is held
    assign o_ready = w_en && i_rst_n;

    logic [12:0] r_vld_a;
    logic [7:0]  r_vld_q;
    logic        div_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= '0;
            r_vld_q <= '0;
        end else if (w_en) begin
            r_vld_a <= {r_vld_a[11:0], i_valid};
            r_vld_q <= {r_vld_q[6:0], div_vld};
        end
    end

    // ---------------- temperature front end ----------------
    logic signed [17:0] r1_ta;
    logic signed [16:0] r1_td;
    logic [20:0]        r1_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ta <= $signed({1'b0, i_raw_temperature[19:3]}) - $signed({1'b0, cal_t1, 1'b0});
            r1_td <= $signed({1'b0, i_raw_temperature[19:4]}) - $signed({1'b0, cal_t1});
            r1_np <= 21'h100000 - {1'b0, i_raw_pressure};
        end
    end

    logic signed [33:0] n2_tat2, n2_tdsq;
    logic signed [33:0] r2_tat2;
    logic [31:0]        r2_tdsq;
    logic [20:0]        r2_np;

    assign n2_tat2 = r1_ta * cal_t2;
    assign n2_tdsq = r1_td * r1_td;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tat2 <= n2_tat2;
            r2_tdsq <= n2_tdsq[31:0];
            r2_np   <= r1_np;
        end
    end

    logic signed [36:0] n3_b0;
    logic signed [36:0] r3_b0;
    logic signed [22:0] r3_a;
    logic [20:0]        r3_np;

    assign n3_b0 = $signed({1'b0, r2_tdsq[31:12]}) * cal_t3;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a  <= r2_tat2[33:11];
            r3_b0 <= n3_b0;
            r3_np <= r2_np;
        end
    end

    logic signed [23:0] r4_tfine;
    logic [20:0]        r4_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_tfine <= $signed({r3_a[22], r3_a}) + $signed({r3_b0[36], r3_b0[36:14]});
            r4_np    <= r3_np;
        end
    end

    logic signed [26:0] n5_tf;
    logic signed [24:0] r5_x1;
    logic signed [26:0] r5_c5;
    logic [20:0]        r5_np;

    assign n5_tf = 27'(r4_tfine);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_x1 <= 25'(r4_tfine) - 25'sd128000;
            r5_c5 <= (n5_tf <<< 2) + n5_tf + 27'sd128;
            r5_np <= r4_np;
        end
    end

    // ---------------- pressure polynomial ----------------
    logic signed [49:0]     n6_sq;
    logic signed [40:0]     n6_x1p5, n6_x1p2;
    logic signed [18:0]     n6_c19;
    logic signed [CelW-1:0] n6_cel;

    assign n6_sq   = r5_x1 * r5_x1;
    assign n6_x1p5 = r5_x1 * cal_p5;
    assign n6_x1p2 = r5_x1 * cal_p2;
    assign n6_c19  = r5_c5[26:8];

    always_comb begin
        if (n6_c19 < 19'(CelMin)) begin
            n6_cel = CelMin;
        end else if (n6_c19 > 19'(CelMax)) begin
            n6_cel = CelMax;
        end else begin
            n6_cel = n6_c19[CelW-1:0];
        end
    end

    logic signed [49:0]     r6_sq;
    logic signed [40:0]     r6_x1p5, r6_x1p2;
    logic signed [CelW-1:0] r6_cel;
    logic [20:0]            r6_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sq   <= n6_sq;
            r6_x1p5 <= n6_x1p5;
            r6_x1p2 <= n6_x1p2;
            r6_cel  <= n6_cel;
            r6_np   <= r5_np;
        end
    end

    logic signed [40:0] n7_p6lo, n7_p3lo;
    logic signed [41:0] n7_p6hi, n7_p3hi;
    logic signed [17:0] n7_c18;

    assign n7_p6lo = $signed({1'b0, r6_sq[23:0]}) * cal_p6;
    assign n7_p3lo = $signed({1'b0, r6_sq[23:0]}) * cal_p3;
    assign n7_p6hi = $signed(r6_sq[49:24]) * cal_p6;
    assign n7_p3hi = $signed(r6_sq[49:24]) * cal_p3;
    assign n7_c18  = 18'(r6_cel);

    logic signed [40:0]     r7_p6lo, r7_p3lo, r7_x1p5, r7_x1p2;
    logic signed [41:0]     r7_p6hi, r7_p3hi;
    logic signed [17:0]     r7_m9;
    logic signed [CelW-1:0] r7_cel;
    logic [20:0]            r7_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_p6lo <= n7_p6lo;
            r7_p3lo <= n7_p3lo;
            r7_p6hi <= n7_p6hi;
            r7_p3hi <= n7_p3hi;
            r7_m9   <= (n7_c18 <<< 3) + n7_c18;
            r7_x1p5 <= r6_x1p5;
            r7_x1p2 <= r6_x1p2;
            r7_cel  <= r6_cel;
            r7_np   <= r6_np;
        end
    end

    logic signed [17:0]     n8_negm9;
    logic signed [63:0]     r8_x2a, r8_x1ba;
    logic signed [40:0]     r8_x1p5, r8_x1p2;
    logic [16:0]            r8_mag;
    logic                   r8_mneg;
    logic signed [CelW-1:0] r8_cel;
    logic [20:0]            r8_np;

    assign n8_negm9 = -r7_m9;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_x2a  <= 64'(r7_p6lo) + (64'(r7_p6hi) <<< 24);
            r8_x1ba <= 64'(r7_p3lo) + (64'(r7_p3hi) <<< 24);
            r8_mag  <= r7_m9[17] ? n8_negm9[16:0] : r7_m9[16:0];
            r8_mneg <= r7_m9[17];
            r8_x1p5 <= r7_x1p5;
            r8_x1p2 <= r7_x1p2;
            r8_cel  <= r7_cel;
            r8_np   <= r7_np;
        end
    end

    logic signed [63:0]     r9_x2, r9_x1b;
    logic [32:0]            r9_q;
    logic                   r9_mneg;
    logic signed [CelW-1:0] r9_cel;
    logic [20:0]            r9_np;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_x2   <= r8_x2a + (64'(r8_x1p5) <<< 17) + (64'(cal_p4) <<< 35);
            r9_x1b  <= (r8_x1ba >>> 8) + (64'(r8_x1p2) <<< 12) + 64'sh0000_8000_0000_0000;
            // divide by five as a reciprocal multiply, exact below 2^18
            r9_q    <= r8_mag * 16'd52429;
            r9_mneg <= r8_mneg;
            r9_cel  <= r8_cel;
            r9_np   <= r8_np;
        end
    end

    logic [47:0]            n10_x1bl, n10_x1bh;
    logic signed [FahW-1:0] n10_fq;
    logic [63:0]            r10_num0;
    logic [47:0]            r10_x1bl;
    logic [31:0]            r10_x1bh;
    logic signed [CelW-1:0] r10_cel;
    logic signed [FahW-1:0] r10_fah;

    assign n10_x1bl = r9_x1b[31:0] * cal_p1;
    assign n10_x1bh = r9_x1b[63:32] * cal_p1;
    assign n10_fq   = $signed({1'b0, r9_q[32:18]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_num0 <= {12'b0, r9_np, 31'b0} - r9_x2;
            r10_x1bl <= n10_x1bl;
            r10_x1bh <= n10_x1bh[31:0];
            r10_fah  <= r9_mneg ? (16'sd3200 - n10_fq) : (16'sd3200 + n10_fq);
            r10_cel  <= r9_cel;
        end
    end

    logic [63:0]            n11_prod;
    logic [43:0]            n11_n3l, n11_n3h;
    logic signed [DenW-1:0] r11_div;
    logic [43:0]            r11_n3l;
    logic [31:0]            r11_n3h;
    logic signed [CelW-1:0] r11_cel;
    logic signed [FahW-1:0] r11_fah;

    assign n11_prod = {16'b0, r10_x1bl} + {r10_x1bh, 32'b0};
    assign n11_n3l  = r10_num0[31:0] * 12'd3125;
    assign n11_n3h  = r10_num0[63:32] * 12'd3125;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_div <= $signed(n11_prod[63:33]);
            r11_n3l <= n11_n3l;
            r11_n3h <= n11_n3h[31:0];
            r11_cel <= r10_cel;
            r11_fah <= r10_fah;
        end
    end

    logic signed [DenW-1:0] n12_negdiv;
    logic [63:0]            r12_num;
    logic [DenW-1:0]        r12_md;
    logic                   r12_dneg, r12_fault;
    logic signed [CelW-1:0] r12_cel;
    logic signed [FahW-1:0] r12_fah;

    assign n12_negdiv = -r11_div;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_num   <= {20'b0, r11_n3l} + {r11_n3h, 32'b0};
            r12_md    <= r11_div[DenW-1] ? n12_negdiv : r11_div;
            r12_dneg  <= r11_div[DenW-1];
            r12_fault <= (r11_div == '0);
            r12_cel   <= r11_cel;
            r12_fah   <= r11_fah;
        end
    end

    logic [63:0]     r13_mn;
    logic [DenW-1:0] r13_md;
    t_div_side       r13_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_mn         <= r12_num[63] ? (64'd0 - r12_num) : r12_num;
            r13_md         <= r12_md;
            r13_side.neg   <= r12_num[63] ^ r12_dneg;
            r13_side.fault <= r12_fault;
            r13_side.cel   <= r12_cel;
            r13_side.fah   <= r12_fah;
        end
    end

    // ---------------- division ----------------
    logic [63:0] div_quo;
    t_div_side   div_side;

    ptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld_a[12]),
        .i_num   (r13_mn),
        .i_den   (r13_md),
        .i_side  (r13_side),
        .o_vld   (div_vld),
        .o_quo   (div_quo),
        .o_side  (div_side)
    );

    // ---------------- pressure back end ----------------
    logic signed [63:0] rq1_p;
    t_div_side          rq1_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq1_p    <= div_side.neg ? $signed(64'd0 - div_quo) : $signed(div_quo);
            rq1_side <= div_side;
        end
    end

    logic signed [63:0] nq2_s;
    logic [63:0]        nq2_lolo, nq2_lohi;
    logic signed [48:0] nq2_p8l, nq2_p8h;

    assign nq2_s    = rq1_p >>> 13;
    assign nq2_lolo = nq2_s[31:0] * nq2_s[31:0];
    assign nq2_lohi = nq2_s[31:0] * nq2_s[63:32];
    assign nq2_p8l  = cal_p8 * $signed({1'b0, rq1_p[31:0]});
    assign nq2_p8h  = cal_p8 * $signed({1'b0, rq1_p[63:32]});

    logic [63:0]        rq2_lolo;
    logic [30:0]        rq2_lohi;
    logic signed [48:0] rq2_p8l;
    logic [31:0]        rq2_p8h;
    logic signed [63:0] rq2_p;
    t_div_side          rq2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq2_lolo <= nq2_lolo;
            rq2_lohi <= nq2_lohi[30:0];
            rq2_p8l  <= nq2_p8l;
            rq2_p8h  <= nq2_p8h[31:0];
            rq2_p    <= rq1_p;
            rq2_side <= rq1_side;
        end
    end

    logic signed [63:0] nq3_p8p;
    logic [63:0]        rq3_sq2;
    logic signed [63:0] rq3_x2, rq3_p;
    t_div_side          rq3_side;

    // square mod 2^64: the cross term counts twice, the high square drops out
    assign nq3_p8p = 64'(rq2_p8l) + $signed({rq2_p8h, 32'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq3_sq2  <= rq2_lolo + {rq2_lohi, 33'b0};
            rq3_x2   <= nq3_p8p >>> 19;
            rq3_p    <= rq2_p;
            rq3_side <= rq2_side;
        end
    end

    logic signed [48:0] nq4_p9l, nq4_p9h;
    logic signed [48:0] rq4_p9l;
    logic [31:0]        rq4_p9h;
    logic signed [63:0] rq4_x2, rq4_p;
    t_div_side          rq4_side;

    assign nq4_p9l = cal_p9 * $signed({1'b0, rq3_sq2[31:0]});
    assign nq4_p9h = cal_p9 * $signed({1'b0, rq3_sq2[63:32]});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq4_p9l  <= nq4_p9l;
            rq4_p9h  <= nq4_p9h[31:0];
            rq4_x2   <= rq3_x2;
            rq4_p    <= rq3_p;
            rq4_side <= rq3_side;
        end
    end

    logic signed [63:0] nq5_p9s;
    logic signed [63:0] rq5_x1q, rq5_x2, rq5_p;
    t_div_side          rq5_side;

    assign nq5_p9s = 64'(rq4_p9l) + $signed({rq4_p9h, 32'b0});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq5_x1q  <= nq5_p9s >>> 25;
            rq5_x2   <= rq4_x2;
            rq5_p    <= rq4_p;
            rq5_side <= rq4_side;
        end
    end

    logic signed [63:0] rq6_sum;
    t_div_side          rq6_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq6_sum  <= rq5_p + rq5_x1q + rq5_x2;
            rq6_side <= rq5_side;
        end
    end

    logic signed [63:0] rq7_v;
    t_div_side          rq7_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq7_v    <= (rq6_sum >>> 8) + (64'(cal_p7) <<< 4);
            rq7_side <= rq6_side;
        end
    end

    logic signed [63:0] nq8_r;
    logic signed [63:0] rq8_w;
    t_div_side          rq8_side;

    assign nq8_r = rq7_v + 64'sd128;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rq8_w    <= nq8_r >>> 8;
            rq8_side <= rq7_side;
        end
    end

    logic [PaW-1:0] n_pa;

    always_comb begin
        if (rq8_side.fault) begin
            n_pa = PaMin;
        end else if (rq8_w < $signed({47'b0, PaMin})) begin
            n_pa = PaMin;
        end else if (rq8_w > $signed({47'b0, PaMax})) begin
            n_pa = PaMax;
        end else begin
            n_pa = rq8_w[PaW-1:0];
        end
    end

    // ---------------- output register and skid stage ----------------
    logic                   r_skid_fault;
    logic signed [CelW-1:0] r_skid_cel;
    logic signed [FahW-1:0] r_skid_fah;
    logic [PaW-1:0]         r_skid_pa;
    logic                   w_take, w_arrive;

    assign w_take   = r_out_vld && i_ready;
    assign w_arrive = w_en && r_vld_q[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_arrive) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                o_celsius_hundredths    <= r_skid_cel;
                o_fahrenheit_hundredths <= r_skid_fah;
                o_pressure_pascal       <= r_skid_pa;
                o_divide_fault          <= r_skid_fault;
            end
        end else if (w_arrive) begin
            if (!r_out_vld || w_take) begin
                o_celsius_hundredths    <= rq8_side.cel;
                o_fahrenheit_hundredths <= rq8_side.fah;
                o_pressure_pascal       <= n_pa;
                o_divide_fault          <= rq8_side.fault;
            end else begin
                r_skid_cel   <= rq8_side.cel;
                r_skid_fah   <= rq8_side.fah;
                r_skid_pa    <= n_pa;
                r_skid_fault <= rq8_side.fault;
            end
        end
    end

    assign o_valid = r_out_vld;

endmodule
